// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file ssc_checker.sv
// no dependencies; both macros expect clk in scope, and SSC_ASSERT also expects rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
// shared types, constants and the crc-8/maxim byte update for the scratchpad checker
// no dependencies
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned STATUS_W = 2;

  // index of the crc byte, the last one of a frame
  localparam logic [POS_W-1:0] LAST_POS = 4'd8;

  // expected reserved byte values
  localparam logic [BYTE_W-1:0] OK_FF    = 8'hFF;
  localparam logic [BYTE_W-1:0] OK_SEVEN = 8'h10;
  localparam logic [BYTE_W-1:0] LINE_OPEN_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] LINE_SHORT_BYTE = 8'h00;

  // per-bit xor terms of one reflected 0x31 byte update
  localparam logic [BYTE_W-1:0] CRC_TERMS [BYTE_W] = '{
    8'h5E, 8'hBC, 8'h61, 8'hC2, 8'h9D, 8'h23, 8'h46, 8'h8C
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_OPEN  = 2'd1,
    ST_SHORT = 2'd2,
    ST_CRC   = 2'd3
  } status_t;

  // one byte of crc-8/maxim
  function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] r;
    x = crc ^ b;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (x[i]) r = r ^ CRC_TERMS[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/sensor_scratchpad_checker_core.sv =====
// an input beat reaches its result beat through the input register, then the result register
// throughput: one scratchpad byte per cycle; one result beat per nine input bytes
// back pressure on the result side stalls only the crc byte, held in the input register
// reset: rst_n synchronous, active low; clears the frame state and both valid flags
// depends on ssc_pkg
`timescale 1ns / 1ps

module sensor_scratchpad_checker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ssc_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] scratch_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssc_pkg::TEMP_W-1:0]    out_tdata,  // [15:0] temperature
  output logic [ssc_pkg::STATUS_W-1:0]  out_tuser   // [1:0] status
);
  import ssc_pkg::*;

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] byte_r;

  // frame state
  logic [BYTE_W-1:0] crc_r,     crc_nxt;
  logic [POS_W-1:0]  pos_r,     pos_nxt;
  logic [BYTE_W-1:0] temp_lo_r, temp_lo_nxt;
  logic [BYTE_W-1:0] temp_hi_r, temp_hi_nxt;
  logic              ff_ok_r,   ff_ok_nxt;
  logic [BYTE_W-1:0] seven_r,   seven_nxt;

  // result register
  logic              out_vld_r;
  logic [TEMP_W-1:0] temp_r,    temp_nxt;
  status_t           status_r,  status_nxt;

  logic [BYTE_W-1:0] crc_upd;
  logic              is_last;
  logic              frame_ok;
  logic              out_free;
  logic              stage_adv;

  // handshake between the two registers
  assign is_last   = (pos_r >= LAST_POS);
  assign out_free  = !out_vld_r || out_tready;
  assign stage_adv = in_vld_r && (!is_last || out_free);
  assign in_tready = !in_vld_r || stage_adv;

  // crc and frame check
  assign crc_upd  = crc_step(crc_r, byte_r);
  assign frame_ok = (crc_upd == '0) && ff_ok_r && (seven_r == OK_SEVEN);

  // next frame state
  always_comb begin
    crc_nxt     = crc_r;
    pos_nxt     = pos_r;
    temp_lo_nxt = temp_lo_r;
    temp_hi_nxt = temp_hi_r;
    ff_ok_nxt   = ff_ok_r;
    seven_nxt   = seven_r;
    if (stage_adv) begin
      if (is_last) begin
        crc_nxt     = '0;
        pos_nxt     = '0;
        temp_lo_nxt = '0;
        temp_hi_nxt = '0;
        ff_ok_nxt   = 1'b0;
        seven_nxt   = '0;
      end else begin
        crc_nxt = crc_upd;
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd0) temp_lo_nxt = byte_r;
        if (pos_r == 4'd1) temp_hi_nxt = byte_r;
        if (pos_r == 4'd5) ff_ok_nxt   = (byte_r == OK_FF);
        if (pos_r == 4'd7) seven_nxt   = byte_r;
      end
    end
  end

  // result value
  always_comb begin
    temp_nxt = '0;
    if (frame_ok) begin
      temp_nxt   = {temp_hi_r, temp_lo_r};
      status_nxt = ST_OK;
    end else if (seven_r == LINE_OPEN_BYTE) begin
      status_nxt = ST_OPEN;
    end else if (seven_r == LINE_SHORT_BYTE) begin
      status_nxt = ST_SHORT;
    end else begin
      status_nxt = ST_CRC;
    end
  end

  // control and frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      crc_r     <= '0;
      pos_r     <= '0;
      temp_lo_r <= '0;
      temp_hi_r <= '0;
      ff_ok_r   <= 1'b0;
      seven_r   <= '0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (stage_adv && is_last) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      crc_r     <= crc_nxt;
      pos_r     <= pos_nxt;
      temp_lo_r <= temp_lo_nxt;
      temp_hi_r <= temp_hi_nxt;
      ff_ok_r   <= ff_ok_nxt;
      seven_r   <= seven_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) byte_r <= in_tdata;
    if (stage_adv && is_last) begin
      temp_r   <= temp_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = temp_r;
  assign out_tuser  = status_r;

endmodule

// ===== rtl/ssc_checker.sv =====
// port-level assertions for the scratchpad checker, bound to the top level
// depends on ssc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [ssc_pkg::BYTE_W-1:0]    in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ssc_pkg::TEMP_W-1:0]    out_tdata,
  input logic [ssc_pkg::STATUS_W-1:0]  out_tuser
);
  import ssc_pkg::*;

  // nothing is offered on the result side right after reset
  `SSC_ASSERT_ALWAYS(a_out_idle_after_rst, !rst_n |=> !out_tvalid, "result valid after reset")

  // a failed frame always reports zero temperature
  `SSC_ASSERT(a_bad_frame_zero_temp, out_tvalid && (out_tuser != ST_OK) |-> out_tdata == '0, "nonzero temperature on failed frame")

  // a stalled result beat holds its payload
  `SSC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  // a fresh result beat must be preceded by an accepted input beat
  `SSC_ASSERT(a_out_from_in, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "result beat without a preceding input beat")

endmodule

bind sensor_scratchpad_checker_core ssc_checker u_ssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/tb_sensor_scratchpad_checker_core.sv =====
// testbench for sensor_scratchpad_checker_core: scratchpad frames in, checked readings out
// depends on ssc_pkg and the rtl; a scoreboard class predicts each reading from the bytes it sees
`timescale 1ns / 1ps

// reflected crc-8/maxim polynomial for the bit-serial update
localparam logic [7:0] MAXIM_POLY_REFL = 8'h8C;

// byte positions within a scratchpad frame
localparam int POS_TEMP_LO   = 0;
localparam int POS_TEMP_HI   = 1;
localparam int POS_RSVD_FF   = 5;
localparam int POS_RSVD_7    = 7;
localparam int FRAME_LEN     = 9;

typedef logic [7:0] frame_t [FRAME_LEN];

typedef struct packed {
  logic [15:0]      temp;
  ssc_pkg::status_t status;
} reading_t;

// tracks frame state and holds the readings still owed by the block
class scratchpad_scoreboard;
  logic [7:0]  crc;
  logic [3:0]  pos;
  logic [7:0]  temp_lo;
  logic [7:0]  temp_hi;
  bit          ff_ok;
  logic [7:0]  rsvd7;
  reading_t    owed[$];
  int          errors;
  int          readings_seen;

  function new();
    clear_frame();
    errors = 0;
    readings_seen = 0;
  endfunction

  function void clear_frame();
    crc = '0;
    pos = '0;
    temp_lo = '0;
    temp_hi = '0;
    ff_ok = 0;
    rsvd7 = '0;
  endfunction

  // bit-serial crc-8/maxim over one byte
  function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ MAXIM_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  // accepted input beat
  function void note_byte(logic [7:0] b);
    logic [7:0] nxt;
    reading_t   rd;
    nxt = crc_update(crc, b);
    if (pos < ssc_pkg::LAST_POS) begin
      case (int'(pos))
        POS_TEMP_LO: temp_lo = b;
        POS_TEMP_HI: temp_hi = b;
        POS_RSVD_FF: ff_ok = (b == ssc_pkg::OK_FF);
        POS_RSVD_7:  rsvd7 = b;
        default: ;
      endcase
      crc = nxt;
      pos = pos + 4'd1;
    end else begin
      // crc byte closes the frame
      if (nxt == 8'h00 && ff_ok && rsvd7 == ssc_pkg::OK_SEVEN) begin
        rd.temp = {temp_hi, temp_lo};
        rd.status = ssc_pkg::ST_OK;
      end else begin
        rd.temp = '0;
        if (rsvd7 == ssc_pkg::LINE_OPEN_BYTE) rd.status = ssc_pkg::ST_OPEN;
        else if (rsvd7 == ssc_pkg::LINE_SHORT_BYTE) rd.status = ssc_pkg::ST_SHORT;
        else rd.status = ssc_pkg::ST_CRC;
      end
      owed.push_back(rd);
      clear_frame();
    end
  endfunction

  // accepted output beat
  function void check_reading(logic [15:0] temp, ssc_pkg::status_t status);
    reading_t want;
    readings_seen++;
    if (owed.size() == 0) begin
      $display("%0t: unexpected reading temp %0d status %s", $time, $signed(temp),
               status.name());
      errors++;
      return;
    end
    want = owed.pop_front();
    if (temp !== want.temp) begin
      $display("%0t: temperature mismatch, expected %0d, got %0d", $time,
               $signed(want.temp), $signed(temp));
      errors++;
    end
    if (status !== want.status) begin
      $display("%0t: status mismatch, expected %s, got %s", $time, want.status.name(),
               status.name());
      errors++;
    end
  endfunction

  function int pending();
    return owed.size();
  endfunction
endclass

module tb_sensor_scratchpad_checker_core;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int RANDOM_FRAMES = 105;
  localparam int HOLD_AFTER_READINGS = 30;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {
    FR_GOOD, FR_OPEN, FR_SHORT, FR_BAD_CRC, FR_BAD_FF, FR_ODD_RSVD7, FR_NOISE
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] scratch_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] temperature
  logic [1:0]  out_tuser;          // [1:0] status

  scratchpad_scoreboard sb = new();
  bit steady = 0;

  sensor_scratchpad_checker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // idle length on the input side: mostly none, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // offer one beat and wait for it to be taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
  endtask

  task automatic send_frame(frame_t f);
    for (int i = 0; i < FRAME_LEN; i++) send_byte(f[i]);
  endtask

  // random temperature, mostly in sensor range, sometimes at the extremes
  function automatic logic [15:0] pick_temp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'($urandom);
    return 16'($signed($urandom_range(0, 180 * 16)) - 55 * 16);
  endfunction

  // scratchpad frame of the given kind with random content
  function automatic frame_t build_frame(frame_kind_t kind, logic [15:0] temp);
    frame_t     f;
    logic [7:0] c;
    int         k;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'($urandom);
    if (kind == FR_NOISE) return f;
    f[POS_TEMP_LO] = temp[7:0];
    f[POS_TEMP_HI] = temp[15:8];
    f[POS_RSVD_FF] = ssc_pkg::OK_FF;
    f[POS_RSVD_7] = ssc_pkg::OK_SEVEN;
    case (kind)
      FR_OPEN:  f[POS_RSVD_7] = ssc_pkg::LINE_OPEN_BYTE;
      FR_SHORT: f[POS_RSVD_7] = ssc_pkg::LINE_SHORT_BYTE;
      FR_BAD_FF: begin
        do f[POS_RSVD_FF] = 8'($urandom); while (f[POS_RSVD_FF] == ssc_pkg::OK_FF);
      end
      FR_ODD_RSVD7: f[POS_RSVD_7] = 8'($urandom);
      default: ;
    endcase
    c = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) c = sb.crc_update(c, f[i]);
    f[FRAME_LEN-1] = c;
    // single bit flip anywhere in the frame
    if (kind == FR_BAD_CRC) begin
      k = $urandom_range(0, FRAME_LEN - 1);
      f[k][$urandom_range(0, 7)] ^= 1'b1;
    end
    return f;
  endfunction

  // result side: random ready pattern plus one long hold-off to back the block up
  initial begin
    int run;
    bit level;
    bit held;
    held = 0;
    forever begin
      if (!held && sb.readings_seen >= HOLD_AFTER_READINGS) begin
        held = 1;
        level = 0;
        run = HOLD_CYCLES;
      end else if (steady) begin
        level = 1;
        run = 1;
      end else begin
        run = $urandom_range(0, 99);
        if (run < 60) begin
          level = 1;
          run = $urandom_range(1, 12);
        end else if (run < 92) begin
          level = 0;
          run = $urandom_range(1, 3);
        end else begin
          level = 0;
          run = $urandom_range(10, 40);
        end
      end
      repeat (run) begin
        out_tready <= level;
        @(posedge clk);
        if (rst_n && out_tvalid && out_tready)
          sb.check_reading(out_tdata, ssc_pkg::status_t'(out_tuser));
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    frame_t      f;
    frame_kind_t kind;
    int          r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // most negative valid temperature
    send_frame(build_frame(FR_GOOD, 16'h8000));
    // all ones: open line with a broken crc
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'hFF;
    send_frame(f);
    // all zeros: crc passes but reserved bytes say shorted line
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'h00;
    send_frame(f);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      // every so often a batch of frames with no idling on either side
      if (n % 12 == 0) steady = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) kind = FR_GOOD;
      else if (r < 63) kind = FR_OPEN;
      else if (r < 71) kind = FR_SHORT;
      else if (r < 81) kind = FR_BAD_CRC;
      else if (r < 87) kind = FR_BAD_FF;
      else if (r < 93) kind = FR_ODD_RSVD7;
      else kind = FR_NOISE;
      send_frame(build_frame(kind, pick_temp()));
    end
    steady = 0;
    in_tvalid <= 1'b0;

    // drain, then allow for the pipeline
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
